FILE: rtl/rrtsm_pkg.sv
// Shared types and constants for the round-robin thread and semaphore manager.
package rrtsm_pkg;

  localparam int MAX_THREADS = 16;
  localparam int NUM_SEMS    = 4;
  localparam int TID_W       = 4;
  localparam int SID_W       = 2;
  localparam int CNT_W       = 17;
  localparam int NTHR_W      = 5;
  localparam int VAL_W       = 64;
  localparam logic [CNT_W-1:0] LIMIT_RESET = 17'd65536;

  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_CREATE  = 3'd1,
    MODE_EXIT    = 3'd2,
    MODE_JOIN    = 3'd3,
    MODE_SINIT   = 3'd4,
    MODE_SWAIT   = 3'd5,
    MODE_SPOST   = 3'd6,
    MODE_SDESTROY = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_DEADLOCK = 3'd1,
    STAT_NOTHREAD = 3'd2,
    STAT_INVALID  = 3'd3,
    STAT_OVERFLOW = 3'd4,
    STAT_UNINIT   = 3'd5,
    STAT_FULL     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    TS_READY   = 2'd0,
    TS_RUNNING = 2'd1,
    TS_BLOCKED = 2'd2,
    TS_EXITED  = 2'd3
  } tstate_t;

  typedef struct packed {
    tstate_t            st;
    logic               jv;
    logic [TID_W-1:0]   jid;
  } thr_entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CUR,
    S_CREATE,
    S_TGT,
    S_POST,
    S_WAKE,
    S_BLOCK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DONE
  } fsm_t;

endpackage

FILE: rtl/rrtsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrtsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/round_robin_thread_semaphore_manager.sv
// From the accepting edge most events go through S_CUR to S_DONE; create adds S_CREATE,
// a post that wakes a waiter adds S_POST and S_WAKE, and a round-robin scan adds S_SCAN_RD and S_SCAN_CHK per entry.
// The scan reads one thread-table entry at a time through the table RAM read port.
// busy is high from the cycle after the transfer through the done cycle; one event at a time.
// done pulses one cycle with the result; the receiver cannot stall it.
// Reset (rst, synchronous): no threads, current 0, semaphores uninitialized, limit 65536.
module round_robin_thread_semaphore_manager
  import rrtsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode,
  input  logic [TID_W-1:0]   join_tid,
  input  logic [SID_W-1:0]   sem_index,
  input  logic [CNT_W-1:0]   sem_initial,
  input  logic [VAL_W-1:0]   exit_value,
  input  logic               sem_count_limit_we,
  input  logic [CNT_W-1:0]   sem_count_limit,
  output logic               done,
  output logic [2:0]         status_code,
  output logic [TID_W-1:0]   running_thread,
  output logic               woken_valid,
  output logic [TID_W-1:0]   woken_thread,
  output logic [VAL_W-1:0]   value_out,
  output logic               none_runnable
);

  localparam int FA_W = SID_W + TID_W;

  fsm_t state, state_next;
  mode_t md, md_next;
  logic [TID_W-1:0] tgt, tgt_next;
  logic [SID_W-1:0] si, si_next;
  logic [CNT_W-1:0] init, init_next;
  logic [VAL_W-1:0] xv, xv_next;
  logic [TID_W-1:0] cur, cur_next;
  logic [NTHR_W-1:0] nthr, nthr_next;
  logic [NTHR_W-1:0] nrun, nrun_next;
  logic [NTHR_W-1:0] k, k_next;
  logic [TID_W-1:0] idx, idx_next;
  status_t st, st_next;
  logic wv, wv_next;
  logic [TID_W-1:0] wt, wt_next;
  logic [VAL_W-1:0] vout, vout_next;
  thr_entry_t cur_ent, cur_ent_next;
  logic [CNT_W-1:0] lim;

  logic [CNT_W-1:0]  cnt [NUM_SEMS];
  logic [CNT_W-1:0]  cnt_next [NUM_SEMS];
  logic              finit [NUM_SEMS];
  logic              finit_next [NUM_SEMS];
  logic [TID_W-1:0]  head [NUM_SEMS];
  logic [TID_W-1:0]  head_next [NUM_SEMS];
  logic [TID_W-1:0]  tail [NUM_SEMS];
  logic [TID_W-1:0]  tail_next [NUM_SEMS];
  logic [NTHR_W-1:0] fcnt [NUM_SEMS];
  logic [NTHR_W-1:0] fcnt_next [NUM_SEMS];

  logic             t_we;
  logic [TID_W-1:0] t_waddr, t_raddr;
  thr_entry_t       t_wdata, t_rdata, e;
  logic             f_we;
  logic [FA_W-1:0]  f_waddr, f_raddr;
  logic [TID_W-1:0] f_wdata, f_rdata;
  logic             crun;
  logic [TID_W-1:0] first_idx;

  rrtsm_ram #(.WIDTH($bits(thr_entry_t)), .DEPTH(MAX_THREADS)) u_thr_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  rrtsm_ram #(.WIDTH(TID_W), .DEPTH(NUM_SEMS * MAX_THREADS)) u_fifo_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  assign e    = t_rdata;
  assign crun = (nthr != '0) && (e.st == TS_RUNNING);
  assign first_idx = (({1'b0, cur} + 5'd1) == nthr) ? '0 : cur + 4'd1;

  always_comb begin
    state_next   = state;
    md_next      = md;
    tgt_next     = tgt;
    si_next      = si;
    init_next    = init;
    xv_next      = xv;
    cur_next     = cur;
    nthr_next    = nthr;
    nrun_next    = nrun;
    k_next       = k;
    idx_next     = idx;
    st_next      = st;
    wv_next      = wv;
    wt_next      = wt;
    vout_next    = vout;
    cur_ent_next = cur_ent;
    cnt_next     = cnt;
    finit_next   = finit;
    head_next    = head;
    tail_next    = tail;
    fcnt_next    = fcnt;
    t_we    = 1'b0;
    t_waddr = cur;
    t_wdata = '0;
    t_raddr = cur;
    f_we    = 1'b0;
    f_waddr = {si, tail[si]};
    f_wdata = cur;
    f_raddr = {si, head[si]};
    case (state)
      S_IDLE: begin
        if (start) begin
          md_next    = mode_t'(mode);
          tgt_next   = join_tid;
          si_next    = sem_index;
          init_next  = sem_initial;
          xv_next    = exit_value;
          st_next    = STAT_OK;
          wv_next    = 1'b0;
          wt_next    = '0;
          vout_next  = '0;
          state_next = S_CUR;
        end
      end
      S_CUR: begin
        cur_ent_next = e;
        k_next       = 5'd1;
        idx_next     = first_idx;
        case (md)
          MODE_TICK: begin
            if (nthr == '0) begin
              state_next = S_DONE;
            end else begin
              if (e.st == TS_RUNNING) begin
                t_we    = 1'b1;
                t_wdata = '{st: TS_READY, jv: e.jv, jid: e.jid};
              end
              state_next = S_SCAN_RD;
            end
          end
          MODE_CREATE: begin
            if (nthr == '0) begin
              t_we      = 1'b1;
              t_waddr   = '0;
              t_wdata   = '{st: TS_RUNNING, jv: 1'b0, jid: '0};
              cur_next  = '0;
              nthr_next = 5'd1;
              nrun_next = nrun + 5'd1;
            end
            state_next = S_CREATE;
          end
          MODE_EXIT: begin
            if (!crun) begin
              st_next    = STAT_INVALID;
              state_next = S_DONE;
            end else begin
              t_we      = 1'b1;
              t_wdata   = '{st: TS_EXITED, jv: 1'b0, jid: '0};
              nrun_next = nrun - 5'd1;
              if (e.jv) begin
                wv_next    = 1'b1;
                wt_next    = e.jid;
                vout_next  = xv;
                t_raddr    = e.jid;
                state_next = S_WAKE;
              end else begin
                state_next = S_SCAN_RD;
              end
            end
          end
          MODE_JOIN: begin
            if (nthr == '0 || tgt == cur) begin
              st_next    = STAT_DEADLOCK;
              state_next = S_DONE;
            end else if (!crun) begin
              st_next    = STAT_INVALID;
              state_next = S_DONE;
            end else if ({1'b0, tgt} >= nthr) begin
              st_next    = STAT_NOTHREAD;
              state_next = S_DONE;
            end else begin
              t_raddr    = tgt;
              state_next = S_TGT;
            end
          end
          MODE_SINIT: begin
            state_next = S_DONE;
            if (init > lim || fcnt[si] != '0) begin
              st_next = STAT_INVALID;
            end else begin
              cnt_next[si]   = init;
              finit_next[si] = 1'b1;
              head_next[si]  = '0;
              tail_next[si]  = '0;
            end
          end
          default: begin
            state_next = S_DONE;
            if (!finit[si]) begin
              st_next = STAT_UNINIT;
            end else if (md == MODE_SWAIT) begin
              if (!crun) begin
                st_next = STAT_INVALID;
              end else if (cnt[si] != '0) begin
                cnt_next[si] = cnt[si] - 17'd1;
              end else if (fcnt[si] >= NTHR_W'(MAX_THREADS)) begin
                st_next = STAT_FULL;
              end else begin
                f_we          = 1'b1;
                tail_next[si] = tail[si] + 4'd1;
                fcnt_next[si] = fcnt[si] + 5'd1;
                state_next    = S_BLOCK;
              end
            end else if (md == MODE_SPOST) begin
              if (cnt[si] >= lim) begin
                st_next = STAT_OVERFLOW;
              end else if (fcnt[si] != '0) begin
                state_next = S_POST;
              end else begin
                cnt_next[si] = cnt[si] + 17'd1;
              end
            end else begin
              if (fcnt[si] != '0) begin
                st_next = STAT_INVALID;
              end else begin
                finit_next[si] = 1'b0;
                cnt_next[si]   = '0;
              end
            end
          end
        endcase
      end
      S_CREATE: begin
        state_next = S_DONE;
        if (nthr >= NTHR_W'(MAX_THREADS)) begin
          st_next = STAT_FULL;
        end else begin
          t_we      = 1'b1;
          t_waddr   = nthr[TID_W-1:0];
          t_wdata   = '{st: TS_READY, jv: 1'b0, jid: '0};
          nthr_next = nthr + 5'd1;
          nrun_next = nrun + 5'd1;
          vout_next = VAL_W'(nthr);
        end
      end
      S_TGT: begin
        if (e.st == TS_EXITED) begin
          st_next    = STAT_NOTHREAD;
          state_next = S_DONE;
        end else if (e.jv) begin
          st_next    = STAT_INVALID;
          state_next = S_DONE;
        end else begin
          t_we       = 1'b1;
          t_waddr    = tgt;
          t_wdata    = '{st: e.st, jv: 1'b1, jid: cur};
          state_next = S_BLOCK;
        end
      end
      S_POST: begin
        head_next[si] = head[si] + 4'd1;
        fcnt_next[si] = fcnt[si] - 5'd1;
        wv_next       = 1'b1;
        wt_next       = f_rdata;
        t_raddr       = f_rdata;
        state_next    = S_WAKE;
      end
      S_WAKE: begin
        t_we      = 1'b1;
        t_waddr   = wt;
        t_wdata   = '{st: TS_READY, jv: e.jv, jid: e.jid};
        nrun_next = nrun + 5'd1;
        state_next = (md == MODE_EXIT) ? S_SCAN_RD : S_DONE;
      end
      S_BLOCK: begin
        t_we       = 1'b1;
        t_wdata    = '{st: TS_BLOCKED, jv: cur_ent.jv, jid: cur_ent.jid};
        nrun_next  = nrun - 5'd1;
        state_next = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        t_raddr    = idx;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (e.st == TS_READY || e.st == TS_RUNNING) begin
          cur_next   = idx;
          t_we       = 1'b1;
          t_waddr    = idx;
          t_wdata    = '{st: TS_RUNNING, jv: e.jv, jid: e.jid};
          state_next = S_DONE;
        end else if (k == nthr) begin
          state_next = S_DONE;
        end else begin
          k_next     = k + 5'd1;
          idx_next   = (({1'b0, idx} + 5'd1) == nthr) ? '0 : idx + 4'd1;
          state_next = S_SCAN_RD;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur   <= '0;
      nthr  <= '0;
      nrun  <= '0;
      lim   <= LIMIT_RESET;
      for (int i = 0; i < NUM_SEMS; i++) begin
        cnt[i]   <= '0;
        finit[i] <= 1'b0;
        head[i]  <= '0;
        tail[i]  <= '0;
        fcnt[i]  <= '0;
      end
    end else begin
      state <= state_next;
      cur   <= cur_next;
      nthr  <= nthr_next;
      nrun  <= nrun_next;
      if (sem_count_limit_we) begin
        lim <= sem_count_limit;
      end
      cnt   <= cnt_next;
      finit <= finit_next;
      head  <= head_next;
      tail  <= tail_next;
      fcnt  <= fcnt_next;
    end
  end

  always_ff @(posedge clk) begin
    md      <= md_next;
    tgt     <= tgt_next;
    si      <= si_next;
    init    <= init_next;
    xv      <= xv_next;
    k       <= k_next;
    idx     <= idx_next;
    st      <= st_next;
    wv      <= wv_next;
    wt      <= wt_next;
    vout    <= vout_next;
    cur_ent <= cur_ent_next;
  end

  assign busy           = (state != S_IDLE);
  assign done           = (state == S_DONE);
  assign status_code    = st;
  assign running_thread = cur;
  assign woken_valid    = wv;
  assign woken_thread   = wt;
  assign value_out      = vout;
  assign none_runnable  = (nrun == '0);

endmodule

FILE: rtl/rrtsm_checker.sv
// Port-level checks for the thread manager, bound to the top level.
module rrtsm_props (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status_code,
  input logic        woken_valid,
  input logic [3:0]  woken_thread
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("transfer accepted but busy did not rise");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe while idle");

  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> $past(done))
    else $error("busy dropped without a result");

  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> status_code != 3'd7)
    else $error("undefined status code");

  a_woken_zero: assert property (@(posedge clk) disable iff (rst)
    done && !woken_valid |-> woken_thread == 4'd0)
    else $error("woken_thread set without woken_valid");

endmodule

bind round_robin_thread_semaphore_manager rrtsm_props u_rrtsm_props (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .status_code  (status_code),
  .woken_valid  (woken_valid),
  .woken_thread (woken_thread)
);
